[design/octahedral_normal_encoder_assert.svh]
// Assertion helpers shared by the encoder modules.
// Every property samples on i_clk and is off while i_rst_n is low.
`ifndef OCTAHEDRAL_NORMAL_ENCODER_ASSERT_SVH
`define OCTAHEDRAL_NORMAL_ENCODER_ASSERT_SVH

// Same-cycle implication.
`define ONENC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ONENC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/onenc_pkg.sv]
package onenc_pkg;

    localparam int unsigned COMPONENT_BITS_DEF = 16;

    // Per-item flags that ride along with the divider data
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic neg_z;
        logic deg;
    } t_side;

endpackage

[design/octahedral_normal_encoder.sv]
// Pipeline stages from input transfer to output valid
// (one stage for magnitudes and L1 norm, one divider stage per quotient bit, one output stage).
// Throughput: one normal per cycle unless stalled; the divider gives one quotient bit per stage.
// Each stage has its own valid bit, so a stall closes bubbles and holds full stages.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
`include "octahedral_normal_encoder_assert.svh"

module octahedral_normal_encoder #(
    parameter int unsigned COMPONENT_BITS = onenc_pkg::COMPONENT_BITS_DEF,
    localparam int unsigned IN_DW  = ((3 * COMPONENT_BITS + 7) / 8) * 8,
    localparam int unsigned OUT_DW = ((2 * COMPONENT_BITS + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [IN_DW-1:0]  i_s_axis_tdata,   // normal_x, normal_y, normal_z
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [OUT_DW-1:0] o_m_axis_tdata,   // code_u, code_v
    output logic [0:0]        o_m_axis_tuser    // degenerate
);

    localparam int unsigned W = COMPONENT_BITS;
    localparam logic [W-1:0] ONE     = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};

    logic [W-1:0] in_x;
    logic [W-1:0] in_y;
    logic [W-1:0] in_z;
    logic [W-1:0] n_mx;
    logic [W-1:0] n_my;
    logic [W-1:0] n_mz;
    logic [W:0]   n_l1;

    logic             r_s0_vld;
    logic [W-1:0]     r_s0_mx;
    logic [W-1:0]     r_s0_my;
    logic [W:0]       r_s0_l1;
    onenc_pkg::t_side r_s0_side;
    onenc_pkg::t_side n_s0_side;
    logic             s0_rdy;

    logic             div_rdy;
    logic             div_vld;
    logic [W-1:0]     div_qx;
    logic [W-1:0]     div_qy;
    onenc_pkg::t_side div_side;

    logic             r_out_vld;
    logic [W-1:0]     r_u;
    logic [W-1:0]     r_v;
    logic             r_deg;
    logic [W-1:0]     n_u;
    logic [W-1:0]     n_v;
    logic [W-1:0]     mag_u;
    logic [W-1:0]     mag_v;
    logic             out_rdy;

    assign in_x = i_s_axis_tdata[W-1:0];
    assign in_y = i_s_axis_tdata[2*W-1:W];
    assign in_z = i_s_axis_tdata[3*W-1:2*W];

    // Magnitudes; the most negative code maps to 2^(W-1) exactly
    always_comb begin
        n_mx = in_x[W-1] ? (~in_x + W'(1)) : in_x;
        n_my = in_y[W-1] ? (~in_y + W'(1)) : in_y;
        n_mz = in_z[W-1] ? (~in_z + W'(1)) : in_z;
        n_l1 = {1'b0, n_mx} + {1'b0, n_my} + {1'b0, n_mz};
        n_s0_side.neg_x = in_x[W-1];
        n_s0_side.neg_y = in_y[W-1];
        n_s0_side.neg_z = in_z[W-1];
        n_s0_side.deg   = (in_x == '0) && (in_y == '0) && (in_z == '0);
    end

    assign s0_rdy          = !r_s0_vld || div_rdy;
    assign o_s_axis_tready = s0_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (s0_rdy) begin
            r_s0_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_rdy && i_s_axis_tvalid) begin
            r_s0_mx   <= n_mx;
            r_s0_my   <= n_my;
            r_s0_l1   <= n_l1;
            r_s0_side <= n_s0_side;
        end
    end

    onenc_div #(
        .W (W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s0_vld),
        .o_ready (div_rdy),
        .i_mag_x (r_s0_mx),
        .i_mag_y (r_s0_my),
        .i_l1    (r_s0_l1),
        .i_side  (r_s0_side),
        .o_valid (div_vld),
        .i_ready (out_rdy),
        .o_q_x   (div_qx),
        .o_q_y   (div_qy),
        .o_side  (div_side)
    );

    // Fold when z is negative, apply signs and saturate; degenerate normals give zero
    always_comb begin
        mag_u = div_side.neg_z ? (ONE - div_qy) : div_qx;
        mag_v = div_side.neg_z ? (ONE - div_qx) : div_qy;
        if (div_side.neg_x) begin
            n_u = ~mag_u + W'(1);
        end else begin
            n_u = mag_u[W-1] ? MAX_POS : mag_u;
        end
        if (div_side.neg_y) begin
            n_v = ~mag_v + W'(1);
        end else begin
            n_v = mag_v[W-1] ? MAX_POS : mag_v;
        end
        if (div_side.deg) begin
            n_u = '0;
            n_v = '0;
        end
    end

    assign out_rdy = !r_out_vld || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_rdy) begin
            r_out_vld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && div_vld) begin
            r_u   <= n_u;
            r_v   <= n_v;
            r_deg <= div_side.deg;
        end
    end

    assign o_m_axis_tvalid   = r_out_vld;
    assign o_m_axis_tdata    = OUT_DW'({r_v, r_u});
    assign o_m_axis_tuser[0] = r_deg;

    `ONENC_ASSERT_NOW(a_deg_codes_zero, r_out_vld && r_deg, (r_u == '0) && (r_v == '0), "degenerate normal with nonzero code")
    `ONENC_ASSERT_NOW(a_deg_matches_norm, r_s0_vld, r_s0_side.deg == (r_s0_l1 == '0), "degenerate flag disagrees with L1 norm")
    `ONENC_ASSERT_NEXT(a_accept_fills_s0, i_s_axis_tvalid && o_s_axis_tready, r_s0_vld, "accepted transfer not captured")

endmodule

[design/onenc_div.sv]
`include "octahedral_normal_encoder_assert.svh"

// Restoring divider pipeline: one quotient bit per stage for x and y in parallel.
// Computes q = mag * 2^(W-1) / l1 with mag <= l1, so q lies in 0 .. 2^(W-1).
module onenc_div #(
    parameter int unsigned W = onenc_pkg::COMPONENT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [W-1:0]         i_mag_x,
    input  logic [W-1:0]         i_mag_y,
    input  logic [W:0]           i_l1,
    input  onenc_pkg::t_side     i_side,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [W-1:0]         o_q_x,
    output logic [W-1:0]         o_q_y,
    output onenc_pkg::t_side     o_side
);

    logic [W:0]        r_rx   [W];
    logic [W:0]        r_ry   [W];
    logic [W:0]        r_l1   [W];
    logic [W-1:0]      r_qx   [W];
    logic [W-1:0]      r_qy   [W];
    onenc_pkg::t_side  r_side [W];
    logic [W-1:0]      r_vld;
    logic [W:0]        w_rdy;

    assign w_rdy[W] = i_ready;
    assign o_ready  = w_rdy[0];

    for (genvar j = 0; j < W; j++) begin : gen_stage
        logic [W+1:0]     num_x;
        logic [W+1:0]     num_y;
        logic [W:0]       den;
        logic             vin;
        logic [W-1:0]     qx_in;
        logic [W-1:0]     qy_in;
        onenc_pkg::t_side side_in;
        logic [W+2:0]     diff_x;
        logic [W+2:0]     diff_y;
        logic             ge_x;
        logic             ge_y;

        if (j == 0) begin : gen_first
            assign num_x   = {2'b00, i_mag_x};
            assign num_y   = {2'b00, i_mag_y};
            assign den     = i_l1;
            assign vin     = i_valid;
            assign qx_in   = '0;
            assign qy_in   = '0;
            assign side_in = i_side;
        end else begin : gen_next
            assign num_x   = {r_rx[j-1], 1'b0};
            assign num_y   = {r_ry[j-1], 1'b0};
            assign den     = r_l1[j-1];
            assign vin     = r_vld[j-1];
            assign qx_in   = r_qx[j-1];
            assign qy_in   = r_qy[j-1];
            assign side_in = r_side[j-1];
        end

        assign diff_x = {1'b0, num_x} - {2'b00, den};
        assign diff_y = {1'b0, num_y} - {2'b00, den};
        assign ge_x   = ~diff_x[W+2];
        assign ge_y   = ~diff_y[W+2];

        // A stage takes new data when it is empty or its content moves on
        assign w_rdy[j] = !r_vld[j] || w_rdy[j+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (w_rdy[j]) begin
                r_vld[j] <= vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[j] && vin) begin
                r_rx[j]   <= ge_x ? diff_x[W:0] : num_x[W:0];
                r_ry[j]   <= ge_y ? diff_y[W:0] : num_y[W:0];
                r_qx[j]   <= {qx_in[W-2:0], ge_x};
                r_qy[j]   <= {qy_in[W-2:0], ge_y};
                r_l1[j]   <= den;
                r_side[j] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[W-1];
    assign o_q_x   = r_qx[W-1];
    assign o_q_y   = r_qy[W-1];
    assign o_side  = r_side[W-1];

    `ONENC_ASSERT_NOW(a_rem_x_below_den, r_vld[W-1] && (r_l1[W-1] != '0), r_rx[W-1] < r_l1[W-1], "x remainder not below divisor")
    `ONENC_ASSERT_NOW(a_rem_y_below_den, r_vld[W-1] && (r_l1[W-1] != '0), r_ry[W-1] < r_l1[W-1], "y remainder not below divisor")
    `ONENC_ASSERT_NOW(a_quot_sum_bound, r_vld[W-1] && (r_l1[W-1] != '0), ({1'b0, r_qx[W-1]} + {1'b0, r_qy[W-1]}) <= ((W+1)'(1) << (W-1)), "quotient sum exceeds one")

endmodule

[bench/octahedral_normal_encoder_test.sv]
module octahedral_normal_encoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = onenc_pkg::COMPONENT_BITS_DEF;
    localparam int IN_W = ((3 * CB + 7) / 8) * 8;
    localparam int OUT_W = ((2 * CB + 7) / 8) * 8;
    localparam longint unsigned UNIT = 64'd1 << (CB - 1);
    localparam int PIPE_DEPTH = CB + 2;
    localparam int RANDOM_NORMALS = 1030;
    localparam int HOLD_AFTER = 300;
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_AT = 600;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic signed [CB-1:0] u;
        logic signed [CB-1:0] v;
        logic                 deg;
    } code_t;

    typedef struct {
        int x;
        int y;
        int z;
        bit known;
        int u;
        int v;
        int deg;
    } normal_row_t;

    typedef enum int {MIX_WIDE, MIX_TINY, MIX_RAIL, MIX_SPARSE} mix_e;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [IN_W-1:0]   i_s_axis_tdata;   // normal_x, normal_y, normal_z
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    logic [OUT_W-1:0]  o_m_axis_tdata;   // code_u, code_v
    logic [0:0]        o_m_axis_tuser;   // degenerate

    code_t pending_codes[$];
    int    error_count = 0;
    int    results_seen = 0;
    int    normals_sent = 0;
    int    degenerate_sent = 0;
    int    folded_sent = 0;
    int    input_stall_cycles = 0;
    int    quiet_cycles = 0;
    bit    src_calm = 1'b0;
    bit    sink_calm = 1'b0;
    bit    sink_hold = 1'b0;
    bit    hold_done = 1'b0;

    // Known rows 0-11: zero normal, axis extremes, fold with zero quotients, full scale.
    normal_row_t normal_table[24] = '{
        '{0, 0, 0, 1, 0, 0, 1},
        '{32767, 0, 0, 1, 32767, 0, 0},
        '{-32768, 0, 0, 1, -32768, 0, 0},
        '{0, 32767, 0, 1, 0, 32767, 0},
        '{0, -32768, 0, 1, 0, -32768, 0},
        '{0, 0, 32767, 1, 0, 0, 0},
        '{0, 0, -32768, 1, 32767, 32767, 0},
        '{0, -1, -1, 1, 16384, -32768, 0},
        '{-1, 0, -1, 1, -32768, 16384, 0},
        '{1, 0, 0, 1, 32767, 0, 0},
        '{0, 0, -1, 1, 32767, 32767, 0},
        '{-32768, -32768, -32768, 1, -21846, -21846, 0},
        '{-1, 1, 32767, 0, 0, 0, 0},
        '{1, 1, 1, 0, 0, 0, 0},
        '{-1, -1, 1, 0, 0, 0, 0},
        '{32767, 32767, 32767, 0, 0, 0, 0},
        '{-32768, 32767, 0, 0, 0, 0, 0},
        '{0, 1, -32768, 0, 0, 0, 0},
        '{100, -200, -300, 0, 0, 0, 0},
        '{-12345, 6789, -1000, 0, 0, 0, 0},
        '{-1, -1, -1, 0, 0, 0, 0},
        '{21845, -21845, 21845, 0, 0, 0, 0},
        '{5, -3, 0, 0, 0, 0, 0},
        '{-32768, -32768, 32767, 0, 0, 0, 0}
    };

    int rail_vals[6] = '{32767, -32768, -32767, 1, -1, 0};

    octahedral_normal_encoder #(
        .COMPONENT_BITS(CB)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint unsigned comp_mag(input logic [CB-1:0] a);
        longint unsigned w;
        w = a;
        return a[CB-1] ? (2 * UNIT - w) : w;
    endfunction

    // Negative zero collapses to plain zero; +1.0 clamps to the top code.
    function automatic logic [CB-1:0] signed_code(input longint unsigned mag, input bit neg);
        longint unsigned r;
        if (neg && mag != 0)
            r = 64'd0 - mag;
        else
            r = (mag >= UNIT) ? UNIT - 1 : mag;
        return r[CB-1:0];
    endfunction

    function automatic code_t octa_encode(input logic [CB-1:0] x, y, z);
        longint unsigned ax, ay, az, l1, qx, qy;
        code_t c;
        ax = comp_mag(x);
        ay = comp_mag(y);
        az = comp_mag(z);
        l1 = ax + ay + az;
        c.u = '0;
        c.v = '0;
        c.deg = (l1 == 0);
        if (l1 != 0) begin
            qx = (ax << (CB - 1)) / l1;
            qy = (ay << (CB - 1)) / l1;
            if (!z[CB-1]) begin
                c.u = signed_code(qx, x[CB-1]);
                c.v = signed_code(qy, y[CB-1]);
            end else begin
                c.u = signed_code(UNIT - qy, x[CB-1]);
                c.v = signed_code(UNIT - qx, y[CB-1]);
            end
        end
        return c;
    endfunction

    function automatic logic [CB-1:0] pick_component();
        logic [31:0] r;
        int          t;
        mix_e        mix;
        r = $urandom;
        t = $urandom_range(0, 19);
        mix = (t < 10) ? MIX_WIDE : (t < 14) ? MIX_TINY : (t < 17) ? MIX_RAIL : MIX_SPARSE;
        case (mix)
            MIX_TINY: begin
                t = $urandom_range(0, 16) - 8;
                r = t;
            end
            MIX_RAIL: begin
                t = rail_vals[$urandom_range(0, 5)] + $urandom_range(0, 2) - 1;
                if (t > 32767 || t < -32768)
                    t = rail_vals[0];
                r = t;
            end
            MIX_SPARSE: begin
                if (r[31])
                    r = '0;
            end
            default: ;
        endcase
        return r[CB-1:0];
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Entered and left on a falling edge; tvalid stays high across back-to-back transfers.
    task automatic send_normal(input logic [CB-1:0] x, y, z, input bit known, input code_t want);
        int              gap;
        logic [IN_W-1:0] word;
        if ($urandom_range(0, 39) == 0)
            src_calm = !src_calm;
        gap = (sink_hold || src_calm) ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        word = '0;
        word[3*CB-1:0] = {z, y, x};
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= word;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        pending_codes.push_back(known ? want : octa_encode(x, y, z));
        normals_sent++;
        if (x == '0 && y == '0 && z == '0)
            degenerate_sent++;
        if (z[CB-1])
            folded_sent++;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        normal_row_t row;
        code_t       want;
        logic [CB-1:0] x, y, z;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (normal_table[i]) begin
            row = normal_table[i];
            want.u = row.u[CB-1:0];
            want.v = row.v[CB-1:0];
            want.deg = row.deg[0];
            send_normal(row.x[CB-1:0], row.y[CB-1:0], row.z[CB-1:0], row.known, want);
        end

        for (int n = 0; n < RANDOM_NORMALS; n++) begin
            if (n == DRAIN_AT) begin
                // let the pipeline run dry before going on
                i_s_axis_tvalid <= 1'b0;
                do
                    @(negedge i_clk);
                while (pending_codes.size() != 0);
            end
            if ($urandom_range(0, 49) == 0) begin
                x = '0;
                y = '0;
                z = '0;
            end else begin
                x = pick_component();
                y = pick_component();
                z = pick_component();
            end
            send_normal(x, y, z, 1'b0, '0);
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_codes.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);

        $display("covered %0d normals (%0d from the table), %0d all-zero, %0d with negative z",
                 normals_sent, $size(normal_table), degenerate_sent, folded_sent);
        $display("%0d results checked, input held off for %0d cycles", results_seen,
                 input_stall_cycles);
        if (error_count == 0)
            $display("octahedral_normal_encoder_test: clean");
        else
            $display("octahedral_normal_encoder_test: errors");
        $finish;
    end

    initial begin : drain
        int    stall;
        code_t got, want;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 39) == 0)
                sink_calm = !sink_calm;
            if (results_seen >= HOLD_AFTER && !hold_done) begin
                // long back-pressure: let the pipeline fill and stall the input side
                sink_hold = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                sink_hold = 1'b0;
                hold_done = 1'b1;
            end else begin
                stall = sink_calm ? 0 : $urandom_range(0, 12);
                if (stall > 0) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid)
                @(posedge i_clk);
            results_seen++;
            got.u = o_m_axis_tdata[CB-1:0];
            got.v = o_m_axis_tdata[2*CB-1:CB];
            got.deg = o_m_axis_tuser[0];
            if (pending_codes.size() == 0) begin
                flag_error($sformatf("result with nothing pending: u=%0d v=%0d deg=%0b",
                                     got.u, got.v, got.deg));
            end else begin
                want = pending_codes.pop_front();
                if (got.u !== want.u)
                    flag_error($sformatf("code_u: got %0d, want %0d", got.u, want.u));
                if (got.v !== want.v)
                    flag_error($sformatf("code_v: got %0d, want %0d", got.v, want.v));
                if (got.deg !== want.deg)
                    flag_error($sformatf("degenerate: got %0b, want %0b", got.deg, want.deg));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_s_axis_tvalid && !o_s_axis_tready)
                input_stall_cycles <= input_stall_cycles + 1;
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("no transfer for %0d cycles, %0d results pending", quiet_cycles,
                         pending_codes.size());
                $display("octahedral_normal_encoder_test: errors");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule
